// ===== src/srfn_pkg.sv =====
package srfn_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LIMIT_W    = 17;
  localparam int CNT_W      = 16;

  localparam int PATTERN_MAX_DEF     = 8;
  localparam int REPLACEMENT_MAX_DEF = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES     = 3'd0,
    REG_PATTERN_LEN       = 3'd1,
    REG_REPLACEMENT_BYTES = 3'd2,
    REG_REPLACEMENT_LEN   = 3'd3,
    REG_REPLACE_LIMIT     = 3'd4
  } cfg_reg_t;

  // window cell control: write enable, shift toward cell 0, current fill
  typedef struct packed {
    logic             en;
    logic             shift;
    logic [LEN_W-1:0] fill;
  } win_ctrl_t;

  // output queue cell control
  typedef struct packed {
    logic load;
    logic shift;
  } q_ctrl_t;

  // one pending result
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
    logic              has;
    logic              last;
  } out_slot_t;

endpackage

// ===== src/srfn_in_if.sv =====
interface srfn_in_if;
  import srfn_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== src/srfn_out_if.sv =====
interface srfn_out_if;
  import srfn_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              has_byte;
  logic              out_last;

  modport source (output valid, output out_byte, output has_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input out_last,
                  output ready);
endinterface

// ===== src/srfn_win_cell.sv =====
module srfn_win_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  srfn_pkg::win_ctrl_t         ctrl,
  input  logic [srfn_pkg::BYTE_W-1:0] in_byte,
  input  logic [srfn_pkg::BYTE_W-1:0] pat_byte,
  input  logic [srfn_pkg::BYTE_W-1:0] nbr_app,
  output logic [srfn_pkg::BYTE_W-1:0] byte_app,
  output logic                        eq
);
  import srfn_pkg::*;

  logic [BYTE_W-1:0] stored;

  // the new byte lands in the first free cell
  assign byte_app = (ctrl.fill == LEN_W'(IDX)) ? in_byte : stored;
  assign eq       = (byte_app == pat_byte);

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      stored <= ctrl.shift ? nbr_app : byte_app;
    end
  end

endmodule

// ===== src/srfn_out_cell.sv =====
module srfn_out_cell (
  input  logic                clk,
  input  logic                rst,
  input  srfn_pkg::q_ctrl_t   ctrl,
  input  srfn_pkg::out_slot_t slot_in,
  input  srfn_pkg::out_slot_t nbr,
  output srfn_pkg::out_slot_t q
);
  import srfn_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (ctrl.load) begin
      q <= slot_in;
    end else if (ctrl.shift) begin
      q <= nbr;
    end
  end

endmodule

// ===== src/stream_replace_first_n.sv =====
// Streaming find-and-replace over a byte string.
// in_ch carries one byte per request with in_last marking the end of a string;
// out_ch carries the rewritten string, one byte per request, with has_byte low
// only on a bare end marker (last request's match deleted) and out_last on the
// final request of each string. Registers are written through cfg_we/cfg_idx/
// cfg_wdata; the user must do so only while the block is idle (not enforced).
// A request's first result shows on out_ch in the cycle after it is taken.
// Throughput: one input request per cycle while out_ch is not stalled and each
// request causes at most one result; a request that causes more (a replacement
// or a flush at end of string) holds in_ch, as the output queue drains one
// result per cycle with out_ch ready and takes a new batch only when it holds
// at most the result leaving in the same cycle.
// The window is a row of PATTERN_MAX byte cells that shift toward cell 0 when
// the oldest byte leaves; the output queue is a row of cells shifting toward
// the output port.
// Reset clears the registers to their defaults, empties the window, the
// queue and the replacement count. A stalled receiver holds the head result
// steady and backs up into in_ch as soon as the queue holds any result.
module stream_replace_first_n #(
  parameter int PATTERN_MAX     = srfn_pkg::PATTERN_MAX_DEF,
  parameter int REPLACEMENT_MAX = srfn_pkg::REPLACEMENT_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [srfn_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [srfn_pkg::CFG_DATA_W-1:0] cfg_wdata,
  srfn_in_if.sink                         in_ch,
  srfn_out_if.source                      out_ch
);
  import srfn_pkg::*;

  localparam int FW = $clog2(PATTERN_MAX + 1);
  localparam int QD = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX;

  // ---------------- configuration registers ----------------
  logic [CFG_DATA_W-1:0] pat_bytes;
  logic [LEN_W-1:0]      pat_len;
  logic [CFG_DATA_W-1:0] rep_bytes;
  logic [LEN_W-1:0]      rep_len;
  logic [LIMIT_W-1:0]    limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bytes <= '0;
      pat_len   <= LEN_W'(1);
      rep_bytes <= '0;
      rep_len   <= '0;
      limit     <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_PATTERN_BYTES:     pat_bytes <= cfg_wdata;
        REG_PATTERN_LEN:       pat_len   <= cfg_wdata[LEN_W-1:0];
        REG_REPLACEMENT_BYTES: rep_bytes <= cfg_wdata;
        REG_REPLACEMENT_LEN:   rep_len   <= cfg_wdata[LEN_W-1:0];
        REG_REPLACE_LIMIT:     limit     <= cfg_wdata[LIMIT_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // effective lengths: zero pattern length acts as one, both clamp to the max
  logic [LEN_W-1:0] l_eff;
  logic [LEN_W-1:0] r_eff;

  always_comb begin
    if (pat_len == '0) begin
      l_eff = LEN_W'(1);
    end else if (pat_len > LEN_W'(PATTERN_MAX)) begin
      l_eff = LEN_W'(PATTERN_MAX);
    end else begin
      l_eff = pat_len;
    end
    r_eff = (rep_len > LEN_W'(REPLACEMENT_MAX)) ? LEN_W'(REPLACEMENT_MAX) : rep_len;
  end

  // ---------------- window state ----------------
  logic [FW-1:0]    fill;
  logic [FW-1:0]    fill_app;   // fill after the incoming byte is appended
  logic [LEN_W-1:0] fill_app_w;
  logic [CNT_W-1:0] done_cnt;

  logic              accept;
  logic              do_repl;
  logic              emit_old;
  logic              may_repl;
  logic              match;
  logic [QD-1:0]     eq_vec;
  logic [QD-1:0]     len_mask;
  logic [BYTE_W-1:0] win_app [PATTERN_MAX];
  logic [BYTE_W-1:0] win_ext [QD];
  logic [BYTE_W-1:0] rep_ext [QD];
  win_ctrl_t         wctrl;

  assign accept     = in_ch.valid & in_ch.ready;
  assign fill_app   = (fill == FW'(PATTERN_MAX)) ? fill : fill + 1'b1;
  assign fill_app_w = LEN_W'(fill_app);

  // negative limit (sign bit) means no limit
  assign may_repl = limit[LIMIT_W-1] | (done_cnt < limit[CNT_W-1:0]);
  assign match    = &(eq_vec | ~len_mask);
  assign do_repl  = (fill_app_w == l_eff) & match & may_repl;
  assign emit_old = (fill_app_w >= l_eff);

  assign wctrl.en    = accept;
  assign wctrl.shift = ~do_repl & ~in_ch.in_last & emit_old;
  assign wctrl.fill  = LEN_W'(fill);

  genvar k;
  generate
    for (k = 0; k < QD; k++) begin : g_ext
      assign len_mask[k] = (LEN_W'(k) < l_eff);
      assign rep_ext[k]  = rep_bytes[BYTE_W*k +: BYTE_W];
      if (k < PATTERN_MAX) begin : g_win
        logic [BYTE_W-1:0] nbr;
        if (k + 1 < PATTERN_MAX) begin : g_nbr
          assign nbr = win_app[k+1];
        end else begin : g_end
          assign nbr = '0;
        end
        srfn_win_cell #(.IDX(k)) u_cell (
          .clk      (clk),
          .ctrl     (wctrl),
          .in_byte  (in_ch.in_byte),
          .pat_byte (pat_bytes[BYTE_W*k +: BYTE_W]),
          .nbr_app  (nbr),
          .byte_app (win_app[k]),
          .eq       (eq_vec[k])
        );
        assign win_ext[k] = win_app[k];
      end else begin : g_pad
        assign eq_vec[k]  = 1'b1;
        assign win_ext[k] = '0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      done_cnt <= '0;
    end else if (accept) begin
      if (do_repl || in_ch.in_last) begin
        fill <= '0;
      end else if (emit_old) begin
        fill <= fill_app - 1'b1;
      end else begin
        fill <= fill_app;
      end
      if (in_ch.in_last) begin
        done_cnt <= '0;
      end else if (do_repl && (done_cnt != '1)) begin
        done_cnt <= done_cnt + 1'b1;
      end
    end
  end

  // ---------------- result batch for this request ----------------
  out_slot_t batch [QD];

  always_comb begin
    for (int i = 0; i < QD; i++) begin
      batch[i].data = '0;
      batch[i].has  = 1'b1;
      batch[i].last = 1'b0;
      batch[i].vld  = 1'b0;
      if (do_repl) begin
        if (r_eff == '0) begin
          // match deleted: only a bare end marker if the string ends here
          batch[i].vld  = in_ch.in_last && (i == 0);
          batch[i].has  = 1'b0;
          batch[i].last = in_ch.in_last && (i == 0);
        end else begin
          batch[i].vld  = (LEN_W'(i) < r_eff);
          batch[i].data = rep_ext[i];
          batch[i].last = in_ch.in_last && (LEN_W'(i) == r_eff - 1'b1);
        end
      end else if (in_ch.in_last) begin
        // flush whole window, unchanged
        batch[i].vld  = (LEN_W'(i) < fill_app_w);
        batch[i].data = win_ext[i];
        batch[i].last = (LEN_W'(i) == fill_app_w - 1'b1);
      end else begin
        batch[i].vld  = emit_old && (i == 0);
        batch[i].data = win_ext[0];
      end
    end
  end

  // ---------------- output queue ----------------
  out_slot_t qcell [QD+1];
  q_ctrl_t   qctrl;

  assign qcell[QD]   = '0;
  assign qctrl.load  = accept;
  assign qctrl.shift = out_ch.valid & out_ch.ready;

  // take a new batch once at most the departing result is left
  assign in_ch.ready = ~qcell[0].vld | (out_ch.ready & ~qcell[1].vld);

  generate
    for (k = 0; k < QD; k++) begin : g_q
      srfn_out_cell u_qcell (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (qctrl),
        .slot_in (batch[k]),
        .nbr     (qcell[k+1]),
        .q       (qcell[k])
      );
    end
  endgenerate

  assign out_ch.valid    = qcell[0].vld;
  assign out_ch.out_byte = qcell[0].data;
  assign out_ch.has_byte = qcell[0].has;
  assign out_ch.out_last = qcell[0].last;

endmodule

// ===== src/srfn_checker.sv =====
module srfn_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [srfn_pkg::BYTE_W-1:0] out_byte,
  input logic                        has_byte,
  input logic                        out_last
);
  import srfn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(has_byte)
      && $stable(out_last))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> out_valid)
    else $error("end of string produced no result");

  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> out_last && (out_byte == '0))
    else $error("bare marker not a clean end");

endmodule

bind stream_replace_first_n srfn_checker u_srfn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.in_last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .has_byte  (out_ch.has_byte),
  .out_last  (out_ch.out_last)
);

// ===== test/stream_replace_first_n_test.sv =====
`timescale 1ns / 100ps

module stream_replace_first_n_test;
  import srfn_pkg::*;

  // Run sizing
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE       = 4;      // cycles after the last result
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned MAX_REPORTS  = 20;

  // Register codes outside the defined set; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

  localparam logic [LIMIT_W-1:0] LIMIT_NONE = '1;      // -1: replace every match
  localparam logic [LIMIT_W-1:0] LIMIT_MAX  = 17'd65535;

  // One result of the rewritten string
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              out_last;
  } rewrite_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  srfn_in_if  in_ch();
  srfn_out_if out_ch();

  stream_replace_first_n u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: shadow registers plus the match window
  // ---------------------------------------------------------------------------
  logic [63:0]        find_bytes;
  logic [LEN_W-1:0]   find_len;
  logic [63:0]        subst_bytes;
  logic [LEN_W-1:0]   subst_len;
  logic [LIMIT_W-1:0] subst_limit;
  logic [BYTE_W-1:0]  win [8];
  int unsigned        win_fill;
  int unsigned        subst_count;

  rewrite_t rewrite_q[$];  // rewritten-string results still owed by the block

  // Testbench knobs shared by the processes
  int unsigned src_gap_max  = 0;
  int unsigned sink_gap_max = 0;
  int unsigned sink_hold    = 0;  // long receiver hold-off, counted down by the sink

  int unsigned mismatches  = 0;
  int unsigned bytes_in    = 0;
  int unsigned results_out = 0;
  int unsigned strings_out = 0;
  int unsigned setups      = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_window();
    for (int k = 0; k < 8; k++) win[k] = '0;
    win_fill = 0;
  endfunction

  function automatic void reset_shadow();
    find_bytes  = '0;
    find_len    = 4'd1;
    subst_bytes = '0;
    subst_len   = '0;
    subst_limit = LIMIT_NONE;
    clear_window();
    subst_count = 0;
  endfunction

  // emit the oldest window byte and slide the window down by one
  function automatic void pop_oldest();
    rewrite_q.push_back('{out_byte: win[0], has_byte: 1'b1, out_last: 1'b0});
    for (int k = 0; k < 7; k++) win[k] = win[k + 1];
    win[7] = '0;
    if (win_fill > 0) win_fill--;
  endfunction

  // Works out every result caused by one accepted request
  function automatic void rewrite_step(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned l;
    int unsigned r;
    int unsigned before_n;
    bit          hit;
    rewrite_t    tail;
    l = (find_len == 0) ? 1 : (find_len > 8) ? 8 : find_len;
    r = (subst_len > 8) ? 8 : subst_len;
    before_n = rewrite_q.size();
    if (win_fill < 8) begin
      win[win_fill] = b;
      win_fill++;
    end
    // a match counts only when the window holds exactly the pattern length
    hit = (win_fill == l) && (subst_limit[LIMIT_W-1] || subst_count < subst_limit[15:0]);
    for (int k = 0; k < 8; k++) begin
      if (k < l && win[k] != find_bytes[8*k +: 8]) hit = 1'b0;
    end
    if (hit) begin
      for (int k = 0; k < r; k++) begin
        rewrite_q.push_back('{out_byte: subst_bytes[8*k +: 8], has_byte: 1'b1,
                              out_last: 1'b0});
      end
      if (subst_count < 65535) subst_count++;  // saturating
      clear_window();
    end else if (win_fill >= l) begin
      pop_oldest();
    end
    if (last) begin
      // flush whatever is left, partial matches included
      while (win_fill > 0) pop_oldest();
      if (rewrite_q.size() == before_n) begin
        rewrite_q.push_back('{out_byte: '0, has_byte: 1'b0, out_last: 1'b1});
      end else begin
        tail = rewrite_q.pop_back();
        tail.out_last = 1'b1;
        rewrite_q.push_back(tail);
      end
      clear_window();
      subst_count = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results still owed",
             $time, cycle_count, rewrite_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Observer: shadows register writes, predicts on each accepted request and
  // checks each accepted result against the oldest prediction. Everything is
  // sampled at the edge, so the order of processes in a time step is moot.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : observer
    rewrite_t got;
    rewrite_t want;
    if (rst) begin
      reset_shadow();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_PATTERN_BYTES:     find_bytes  = cfg_wdata;
          REG_PATTERN_LEN:       find_len    = cfg_wdata[LEN_W-1:0];
          REG_REPLACEMENT_BYTES: subst_bytes = cfg_wdata;
          REG_REPLACEMENT_LEN:   subst_len   = cfg_wdata[LEN_W-1:0];
          REG_REPLACE_LIMIT:     subst_limit = cfg_wdata[LIMIT_W-1:0];
          default: ;  // unused index: no effect
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        rewrite_step(in_ch.in_byte, in_ch.in_last);
        bytes_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_byte: out_ch.out_byte, has_byte: out_ch.has_byte,
                out_last: out_ch.out_last};
        results_out++;
        if (got.out_last) strings_out++;
        if (rewrite_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got byte %02h has %0b last %0b",
                     $time, got.out_byte, got.has_byte, got.out_last);
          mismatches++;
        end else begin
          want = rewrite_q.pop_front();
          if (got !== want) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: result %0d expected byte %02h has %0b last %0b, got byte %02h has %0b last %0b",
                       $time, results_out, want.out_byte, want.has_byte, want.out_last,
                       got.out_byte, got.has_byte, got.out_last);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: per result, draw a random pause up to sink_gap_max with ready
  // low, then hold ready high until a request goes through. sink_hold forces
  // a long stall so the block's queue fills and in_ch backs up.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned pause;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        sink_hold--;
      end else begin
        pause = $urandom_range(0, sink_gap_max);
        if (pause != 0) begin
          out_ch.ready <= 1'b0;
          repeat (pause) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk iff out_ch.valid);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side helpers
  // ---------------------------------------------------------------------------
  // one request on in_ch; valid stays up afterwards so back-to-back requests
  // never toggle it inside a step
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned pause;
    pause = $urandom_range(0, src_gap_max);
    if (pause != 0) begin
      in_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    @(posedge clk iff in_ch.ready);
  endtask

  // stop sending, let every owed result arrive, then let the block settle
  // since a request may still be in flight without causing a result; wait a
  // clock edge first so the observer has predicted the last accepted request
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (rewrite_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] pat, input logic [63:0] plen,
                           input logic [63:0] rep, input logic [63:0] rlen,
                           input logic [63:0] lim);
    wait_drained();
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LEN, plen);
    write_reg(REG_REPLACEMENT_BYTES, rep);
    write_reg(REG_REPLACEMENT_LEN, rlen);
    write_reg(REG_REPLACE_LIMIT, lim);
    setups++;
  endtask

  function automatic int unsigned draw_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 8;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // reset values: pattern 00, length 1, empty replacement -> zeros are deleted
  task automatic test_reset_defaults();
    src_gap_max  = 2;
    sink_gap_max = 2;
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b1);
    // whole string deleted -> bare end marker
    send_byte(8'h00, 1'b1);
  endtask

  // pattern "ab" -> "X" under limits of one, zero and unlimited
  task automatic test_replace_limits();
    configure(64'h6261, 2, 64'h58, 1, 1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
    configure(64'h6261, 2, 64'h58, 1, 0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
    // unlimited; trailing "a" is a partial match passed on at the end
    configure(64'h6261, 2, 64'h58, 1, LIMIT_NONE);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b1);
  endtask

  // writes to indexes past the last register change nothing
  task automatic test_unused_index();
    wait_drained();
    for (int i = REG_UNUSED_FIRST; i < 2**CFG_IDX_W; i++) write_reg(CFG_IDX_W'(i), '1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
  endtask

  // full-width pattern and replacement, lengths above the maximum (with junk
  // in the upper data bits), then a zero pattern length that acts as one
  task automatic test_length_extremes();
    configure('1, {32'($urandom), 28'($urandom), 4'hF}, 64'h0807_0605_0403_0201,
              64'h0F, LIMIT_MAX);
    for (int k = 0; k < 7; k++) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    configure(64'hFFFF_FF00, 0, 64'hFF00, 2, LIMIT_NONE);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // shrinking the pattern with three bytes held: the final request skips the
  // match test and flushes the whole window
  task automatic test_shrink_mid_string();
    configure(64'h6463_6261, 4, 64'h58, 1, LIMIT_NONE);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    wait_drained();
    write_reg(REG_PATTERN_LEN, 1);
    send_byte(8'h7A, 1'b1);
  endtask

  // every request expands to eight results, first under a long receiver stall
  task automatic test_output_backpressure();
    configure(64'h61, 1, 64'h4847_4645_4443_4241, 8, LIMIT_NONE);
    src_gap_max  = 0;
    sink_gap_max = 0;
    sink_hold    = 100;
    for (int k = 0; k < 23; k++) send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b1);
    sink_gap_max = 3;
    for (int k = 0; k < 8; k++) send_byte(8'h61, k == 7);
  endtask

  // random setups, each followed by two to four strings; most strings mix whole
  // and partial copies of the pattern with stray bytes, the rest are pure noise
  task automatic test_random_strings();
    logic [BYTE_W-1:0] text_q[$];
    logic [63:0]       pat;
    logic [63:0]       plen;
    logic [63:0]       rlen;
    logic [63:0]       lim;
    int unsigned       eff_len;
    int unsigned       slen;
    int unsigned       pick;
    int unsigned       cut;
    int unsigned       sent;
    bit                noise;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       plen = 0;
        1:       plen = $urandom_range(9, 15);
        2, 3:    plen = 8;
        default: plen = $urandom_range(1, 4);
      endcase
      eff_len = (plen == 0) ? 1 : (plen > 8) ? 8 : plen;
      // small alphabet makes overlapping and repeated matches common
      if ($urandom_range(0, 3) == 0) begin
        pat = {$urandom, $urandom};
      end else begin
        for (int k = 0; k < 8; k++) pat[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 2));
      end
      case ($urandom_range(0, 9))
        0:       rlen = $urandom_range(9, 15);
        1:       rlen = 0;
        default: rlen = $urandom_range(0, 8);
      endcase
      case ($urandom_range(0, 6))
        0, 1:    lim = LIMIT_NONE;
        2:       lim = 0;
        3:       lim = 1;
        4:       lim = 2;
        5:       lim = LIMIT_MAX;
        default: lim = $urandom_range(0, 4);
      endcase
      configure(pat, plen, {$urandom, $urandom}, rlen, lim);
      src_gap_max  = draw_gap_max();
      sink_gap_max = draw_gap_max();
      if ($urandom_range(0, 4) == 0) sink_hold = $urandom_range(20, 60);

      repeat ($urandom_range(2, 4)) begin
        text_q.delete();
        slen  = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 30 : 12);
        noise = ($urandom_range(0, 4) == 0);
        while (text_q.size() < slen) begin
          pick = $urandom_range(0, 9);
          if (noise || pick == 9) begin
            text_q.push_back(8'($urandom));
          end else if (pick < 5) begin
            for (int k = 0; k < eff_len; k++) text_q.push_back(pat[8*k +: 8]);
          end else if (pick < 7) begin
            cut = $urandom_range(1, eff_len);
            for (int k = 0; k < cut; k++) text_q.push_back(pat[8*k +: 8]);
          end else begin
            text_q.push_back(8'h61 + 8'($urandom_range(0, 2)));
          end
        end
        for (int k = 0; k < text_q.size(); k++) send_byte(text_q[k], k == text_q.size() - 1);
        sent += text_q.size();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.in_last <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_replace_limits();
    test_unused_index();
    test_length_extremes();
    test_shrink_mid_string();
    test_output_backpressure();
    test_random_strings();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes over %0d register setups, covering limits, length edges",
             bytes_in, setups);
    $display("and a long receiver stall; %0d results checked in %0d strings, %0d mismatches.",
             results_out, strings_out, mismatches);
    if (mismatches == 0 && rewrite_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/srfn_pkg.sv
src/srfn_in_if.sv
src/srfn_out_if.sv
src/srfn_win_cell.sv
src/srfn_out_cell.sv
src/stream_replace_first_n.sv
src/srfn_checker.sv
test/stream_replace_first_n_test.sv
